>>> rtl/pitch_note_segmenter_macros.svh
// ----------------------------------------------------------------------------
// Pitch note segmenter assertion macros
// Concurrent checks clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef PITCH_NOTE_SEGMENTER_MACROS_SVH
`define PITCH_NOTE_SEGMENTER_MACROS_SVH

// same-cycle implication
`define PNS_ASSERT_NOW(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PNS_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/pns_pkg.sv
// ----------------------------------------------------------------------------
// Pitch note segmenter package
// Widths, register codes, reset values and the note record type.
// ----------------------------------------------------------------------------
package pns_pkg;

   localparam int FRAME_BITS     = 20;
   localparam int PITCH_BITS     = 15;
   localparam int FRAC_BITS      = 8;
   localparam int SEMI_BITS      = PITCH_BITS - FRAC_BITS;
   localparam int END_BITS       = FRAME_BITS + 1;
   localparam int COUNT_BITS     = FRAME_BITS + 1;
   localparam int SUM_BITS       = COUNT_BITS + PITCH_BITS;
   localparam int THR_BITS       = 8;
   localparam int SPLIT_BITS     = 4;
   localparam int MINLEN_BITS    = 8;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 8;
   localparam int QUEUE_DEPTH    = 2;
   localparam int DIV_STEPS      = PITCH_BITS;

   localparam logic [FRAME_BITS-1:0] IDX_MAX = '1;
   localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

   localparam logic [THR_BITS-1:0]    THR_RESET       = 8'd128;
   localparam logic [SPLIT_BITS-1:0]  MIN_SPLIT_RESET = 4'd3;
   localparam logic [MINLEN_BITS-1:0] MIN_NOTE_RESET  = 8'd5;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SPLIT_THRESHOLD  = 2'd0,
      CSR_MIN_SPLIT_FRAMES = 2'd1,
      CSR_MIN_NOTE_FRAMES  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [FRAME_BITS-1:0] start_frame;
      logic [END_BITS-1:0]   end_frame;
      logic [SUM_BITS-1:0]   sum;
      logic [COUNT_BITS-1:0] count;
      logic                  last;
   } note_type;

endpackage

>>> rtl/pns_if.sv
// ----------------------------------------------------------------------------
// Pitch note segmenter channels
// Request, response and register-write channels with valid/ready.
// ----------------------------------------------------------------------------
interface pns_req_if import pns_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  voiced;
   logic [PITCH_BITS-1:0] pitch;
   logic                  final_frame;

   modport source (output valid, voiced, pitch, final_frame, input ready);
   modport sink (input valid, voiced, pitch, final_frame, output ready);
endinterface

interface pns_rsp_if import pns_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [FRAME_BITS-1:0] start_frame;
   logic [END_BITS-1:0]   end_frame;
   logic [PITCH_BITS-1:0] mean_pitch;
   logic                  last;

   modport source (output valid, start_frame, end_frame, mean_pitch, last, input ready);
   modport sink (input valid, start_frame, end_frame, mean_pitch, last, output ready);
endinterface

interface pns_csr_if import pns_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/pns_front.sv
// ----------------------------------------------------------------------------
// Pitch note segmenter front end
// Takes a frame request, updates the open note and queues closed notes.
// ----------------------------------------------------------------------------
`include "pitch_note_segmenter_macros.svh"

module pns_front import pns_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   pns_req_if.sink  req,
   pns_csr_if.sink  csr,
   output logic     push,
   output note_type push_note,
   input  logic     queue_full
);

   typedef enum logic [1:0] {F_IDLE, F_EXEC, F_PUSH} front_state_type;

   front_state_type         state_ff, state_in;
   logic                    voiced_ff, voiced_in;
   logic [PITCH_BITS-1:0]   pitch_ff, pitch_in;
   logic                    final_ff, final_in;
   logic [THR_BITS-1:0]     thr_ff, thr_in;
   logic [SPLIT_BITS-1:0]   min_split_ff, min_split_in;
   logic [MINLEN_BITS-1:0]  min_note_ff, min_note_in;
   logic                    in_note_ff, in_note_in;
   logic [FRAME_BITS-1:0]   note_begin_ff, note_begin_in;
   logic [SEMI_BITS-1:0]    held_ff, held_in;
   logic [SPLIT_BITS-1:0]   run_ff, run_in;
   logic [FRAME_BITS-1:0]   change_begin_ff, change_begin_in;
   logic [FRAME_BITS-1:0]   frame_ff, frame_in;
   logic [SUM_BITS-1:0]     settled_sum_ff, settled_sum_in;
   logic [COUNT_BITS-1:0]   settled_count_ff, settled_count_in;
   logic [SUM_BITS-1:0]     pending_sum_ff, pending_sum_in;
   logic [COUNT_BITS-1:0]   pending_count_ff, pending_count_in;
   note_type                pend_ff [2];
   note_type                pend_in [2];
   logic [1:0]              pend_n_ff, pend_n_in;
   logic                    pend_i_ff, pend_i_in;

   logic [PITCH_BITS:0]     round_sum;
   logic [SEMI_BITS-1:0]    semitone;
   logic [PITCH_BITS-1:0]   ref_pitch;
   logic [PITCH_BITS-1:0]   gap;
   logic                    change;
   logic [COUNT_BITS:0]     total;
   logic                    room;
   note_type                split_note;
   note_type                close_note;
   logic                    split_ok;
   logic                    close_ok;

   function automatic logic note_passes(input note_type n,
                                        input logic [MINLEN_BITS-1:0] min_len);
      logic [END_BITS-1:0] span;
      span = n.end_frame - {1'b0, n.start_frame};
      return (span >= END_BITS'(min_len)) && (n.count != '0);
   endfunction

   assign req.ready = (state_ff == F_IDLE);
   assign csr.ready = 1'b1;
   assign push      = (state_ff == F_PUSH) && !queue_full;
   assign push_note = pend_ff[pend_i_ff];

   assign round_sum = {1'b0, pitch_ff} + (PITCH_BITS+1)'(1 << (FRAC_BITS - 1));
   assign semitone  = round_sum[PITCH_BITS] ? '1 : round_sum[PITCH_BITS-1:FRAC_BITS];
   assign ref_pitch = {held_ff, FRAC_BITS'(0)};
   assign gap       = (pitch_ff > ref_pitch) ? pitch_ff - ref_pitch : ref_pitch - pitch_ff;
   assign change    = (semitone != held_ff) && (gap > PITCH_BITS'(thr_ff));
   assign total     = {1'b0, settled_count_ff} + {1'b0, pending_count_ff};
   assign room      = total < {1'b0, CNT_MAX};

   always_comb begin
      state_in         = state_ff;
      voiced_in        = voiced_ff;
      pitch_in         = pitch_ff;
      final_in         = final_ff;
      thr_in           = thr_ff;
      min_split_in     = min_split_ff;
      min_note_in      = min_note_ff;
      in_note_in       = in_note_ff;
      note_begin_in    = note_begin_ff;
      held_in          = held_ff;
      run_in           = run_ff;
      change_begin_in  = change_begin_ff;
      frame_in         = frame_ff;
      settled_sum_in   = settled_sum_ff;
      settled_count_in = settled_count_ff;
      pending_sum_in   = pending_sum_ff;
      pending_count_in = pending_count_ff;
      pend_in[0]       = pend_ff[0];
      pend_in[1]       = pend_ff[1];
      pend_n_in        = pend_n_ff;
      pend_i_in        = pend_i_ff;
      split_note       = '0;
      close_note       = '0;
      split_ok         = 1'b0;
      close_ok         = 1'b0;

      case (state_ff)
         F_IDLE: begin
            if (req.valid) begin
               voiced_in = req.voiced;
               pitch_in  = req.pitch;
               final_in  = req.final_frame;
               state_in  = F_EXEC;
            end
         end
         F_EXEC: begin
            if (voiced_ff && !in_note_ff) begin
               in_note_in       = 1'b1;
               note_begin_in    = frame_ff;
               held_in          = semitone;
               run_in           = '0;
               settled_sum_in   = SUM_BITS'(pitch_ff);
               settled_count_in = COUNT_BITS'(1);
               pending_sum_in   = '0;
               pending_count_in = '0;
            end else if (voiced_ff) begin
               if (change) begin
                  if (run_ff == '0) begin
                     change_begin_in = frame_ff;
                  end
                  run_in = run_ff + SPLIT_BITS'(1);
                  if (room) begin
                     pending_sum_in   = pending_sum_ff + SUM_BITS'(pitch_ff);
                     pending_count_in = pending_count_ff + COUNT_BITS'(1);
                  end
                  if (run_in >= min_split_ff) begin
                     split_note.start_frame = note_begin_ff;
                     split_note.end_frame   = {1'b0, change_begin_in};
                     split_note.sum         = settled_sum_ff;
                     split_note.count       = settled_count_ff;
                     split_ok               = note_passes(split_note, min_note_ff);
                     note_begin_in          = change_begin_in;
                     held_in                = semitone;
                     run_in                 = '0;
                     settled_sum_in         = pending_sum_in;
                     settled_count_in       = pending_count_in;
                     pending_sum_in         = '0;
                     pending_count_in       = '0;
                  end
               end else begin
                  run_in           = '0;
                  settled_sum_in   = settled_sum_ff + pending_sum_ff;
                  settled_count_in = settled_count_ff + pending_count_ff;
                  pending_sum_in   = '0;
                  pending_count_in = '0;
                  if (room) begin
                     settled_sum_in   = settled_sum_in + SUM_BITS'(pitch_ff);
                     settled_count_in = settled_count_in + COUNT_BITS'(1);
                  end
               end
            end

            if (final_ff) begin
               close_note.start_frame = note_begin_in;
               close_note.end_frame   = {1'b0, frame_ff} + END_BITS'(1);
               close_note.sum         = settled_sum_in + pending_sum_in;
               close_note.count       = settled_count_in + pending_count_in;
               close_ok               = in_note_in && note_passes(close_note, min_note_ff);
               in_note_in             = 1'b0;
               note_begin_in          = '0;
               held_in                = '0;
               run_in                 = '0;
               change_begin_in        = '0;
               frame_in               = '0;
               settled_sum_in         = '0;
               settled_count_in       = '0;
               pending_sum_in         = '0;
               pending_count_in       = '0;
            end else if (frame_ff != IDX_MAX) begin
               frame_in = frame_ff + FRAME_BITS'(1);
            end

            split_note.last = !close_ok;
            close_note.last = 1'b1;
            pend_in[0]      = split_ok ? split_note : close_note;
            pend_in[1]      = close_note;
            pend_n_in       = 2'(split_ok) + 2'(close_ok);
            pend_i_in       = 1'b0;
            state_in        = (pend_n_in == 2'd0) ? F_IDLE : F_PUSH;
         end
         F_PUSH: begin
            if (!queue_full) begin
               if (2'(pend_i_ff) == pend_n_ff - 2'd1) begin
                  state_in = F_IDLE;
               end else begin
                  pend_i_in = 1'b1;
               end
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase

      if (csr.valid) begin
         case (csr.index)
            CSR_SPLIT_THRESHOLD:  thr_in       = csr.data[THR_BITS-1:0];
            CSR_MIN_SPLIT_FRAMES: min_split_in = csr.data[SPLIT_BITS-1:0];
            CSR_MIN_NOTE_FRAMES:  min_note_in  = csr.data[MINLEN_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= F_IDLE;
         thr_ff           <= THR_RESET;
         min_split_ff     <= MIN_SPLIT_RESET;
         min_note_ff      <= MIN_NOTE_RESET;
         in_note_ff       <= 1'b0;
         note_begin_ff    <= '0;
         held_ff          <= '0;
         run_ff           <= '0;
         change_begin_ff  <= '0;
         frame_ff         <= '0;
         settled_sum_ff   <= '0;
         settled_count_ff <= '0;
         pending_sum_ff   <= '0;
         pending_count_ff <= '0;
         pend_n_ff        <= '0;
         pend_i_ff        <= 1'b0;
      end else begin
         state_ff         <= state_in;
         thr_ff           <= thr_in;
         min_split_ff     <= min_split_in;
         min_note_ff      <= min_note_in;
         in_note_ff       <= in_note_in;
         note_begin_ff    <= note_begin_in;
         held_ff          <= held_in;
         run_ff           <= run_in;
         change_begin_ff  <= change_begin_in;
         frame_ff         <= frame_in;
         settled_sum_ff   <= settled_sum_in;
         settled_count_ff <= settled_count_in;
         pending_sum_ff   <= pending_sum_in;
         pending_count_ff <= pending_count_in;
         pend_n_ff        <= pend_n_in;
         pend_i_ff        <= pend_i_in;
      end
      voiced_ff  <= voiced_in;
      pitch_ff   <= pitch_in;
      final_ff   <= final_in;
      pend_ff[0] <= pend_in[0];
      pend_ff[1] <= pend_in[1];
   end

   `PNS_ASSERT_NOW(a_idle_run_clear, !in_note_ff, run_ff == '0, "change run outside a note")
   `PNS_ASSERT_NOW(a_push_has_note, state_ff == F_PUSH, pend_n_ff != 2'd0,
                   "push state without a pending note")

endmodule

>>> rtl/pns_queue.sv
// ----------------------------------------------------------------------------
// Pitch note segmenter note queue
// Short first-in first-out buffer of closed notes between front and back.
// ----------------------------------------------------------------------------
`include "pitch_note_segmenter_macros.svh"

module pns_queue import pns_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  note_type push_note,
   output logic     full,
   input  logic     pop,
   output logic     head_valid,
   output note_type head
);

   localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   note_type              mem_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ff, wr_in;
   logic [PTR_BITS-1:0]   rd_ff, rd_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;

   function automatic logic [PTR_BITS-1:0] bump(input logic [PTR_BITS-1:0] ptr);
      return (ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : ptr + PTR_BITS'(1);
   endfunction

   assign full       = (count_ff == CNT_BITS'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = mem_ff[rd_ff];

   always_comb begin
      wr_in    = push ? bump(wr_ff) : wr_ff;
      rd_in    = pop ? bump(rd_ff) : rd_ff;
      count_in = count_ff + CNT_BITS'(push) - CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= push_note;
      end
   end

   `PNS_ASSERT_NOW(a_no_overflow, push, !full, "note queue overflow")
   `PNS_ASSERT_NOW(a_no_underflow, pop, head_valid, "note queue underflow")

endmodule

>>> rtl/pns_back.sv
// ----------------------------------------------------------------------------
// Pitch note segmenter back end
// Divides a note's pitch sum by its count and presents the response.
// ----------------------------------------------------------------------------
`include "pitch_note_segmenter_macros.svh"

module pns_back import pns_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     head_valid,
   input  note_type head,
   output logic     pop,
   pns_rsp_if.source rsp
);

   localparam int STEP_BITS = $clog2(DIV_STEPS);

   typedef enum logic [1:0] {B_IDLE, B_DIV, B_OUT} back_state_type;

   back_state_type          state_ff, state_in;
   logic [COUNT_BITS-1:0]   rem_ff, rem_in;
   logic [COUNT_BITS-1:0]   divisor_ff, divisor_in;
   logic [PITCH_BITS-1:0]   shift_ff, shift_in;
   logic [STEP_BITS-1:0]    step_ff, step_in;
   logic [FRAME_BITS-1:0]   start_ff, start_in;
   logic [END_BITS-1:0]     end_ff, end_in;
   logic                    last_ff, last_in;

   logic [COUNT_BITS:0]     rem_wide;
   logic [COUNT_BITS:0]     rem_diff;
   logic                    take;

   assign pop             = (state_ff == B_IDLE) && head_valid;
   assign rsp.valid       = (state_ff == B_OUT);
   assign rsp.start_frame = start_ff;
   assign rsp.end_frame   = end_ff;
   assign rsp.mean_pitch  = shift_ff;
   assign rsp.last        = last_ff;

   assign rem_wide = {rem_ff, shift_ff[PITCH_BITS-1]};
   assign rem_diff = rem_wide - {1'b0, divisor_ff};
   assign take     = (rem_wide >= {1'b0, divisor_ff});

   always_comb begin
      state_in   = state_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      shift_in   = shift_ff;
      step_in    = step_ff;
      start_in   = start_ff;
      end_in     = end_ff;
      last_in    = last_ff;
      case (state_ff)
         B_IDLE: begin
            if (head_valid) begin
               rem_in     = head.sum[SUM_BITS-1:PITCH_BITS];
               shift_in   = head.sum[PITCH_BITS-1:0];
               divisor_in = head.count;
               start_in   = head.start_frame;
               end_in     = head.end_frame;
               last_in    = head.last;
               step_in    = '0;
               state_in   = B_DIV;
            end
         end
         B_DIV: begin
            rem_in   = take ? rem_diff[COUNT_BITS-1:0] : rem_wide[COUNT_BITS-1:0];
            shift_in = {shift_ff[PITCH_BITS-2:0], take};
            step_in  = step_ff + STEP_BITS'(1);
            if (step_ff == STEP_BITS'(DIV_STEPS - 1)) begin
               state_in = B_OUT;
            end
         end
         B_OUT: begin
            if (rsp.ready) begin
               state_in = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      shift_ff   <= shift_in;
      start_ff   <= start_in;
      end_ff     <= end_in;
      last_ff    <= last_in;
   end

   `PNS_ASSERT_NOW(a_rem_below_divisor, state_ff == B_DIV, rem_ff < divisor_ff,
                   "partial remainder not below count")
   `PNS_ASSERT_NEXT(a_pop_starts_divide, pop, state_ff == B_DIV, "pop did not start divide")

endmodule

>>> rtl/pitch_note_segmenter.sv
// ----------------------------------------------------------------------------
// Pitch note segmenter
// Splits a stream of pitch frames into notes with start, end and mean pitch.
// req_chan: one pitch frame per request (voiced, pitch Q7.8, final_frame).
// rsp_chan: zero, one or two notes per request; last marks the final one.
// csr_chan: register writes (split threshold, split run, minimum note length),
//    always ready, applied in the cycle after the handshake.
// In the front end a request moves from idle to an execute state and then,
// for each note it closes, to a push state that waits for room in the queue.
// Closed notes pass through a two-entry queue to the back end, whose
// restoring divider forms the mean pitch; the back end loads a note, divides
// and holds the result until rsp_chan takes it before it pops the next note.
// Synchronous reset clears track state and loads the register reset values.
// A stalled rsp_chan holds the response; the queue then fills and req_chan
// holds ready low while a closed note waits for room in the queue.
// ----------------------------------------------------------------------------
module pitch_note_segmenter import pns_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   pns_req_if.sink    req_chan,
   pns_rsp_if.source  rsp_chan,
   pns_csr_if.sink    csr_chan
);

   logic     push;
   note_type push_note;
   logic     queue_full;
   logic     pop;
   logic     head_valid;
   note_type head;

   pns_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .csr        (csr_chan),
      .push       (push),
      .push_note  (push_note),
      .queue_full (queue_full)
   );

   pns_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_note  (push_note),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   pns_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp        (rsp_chan)
   );

endmodule
